// File: sv/frx_pkg.sv
// Package for the framed packet receiver: frame phase encoding, register
// indexes, reset values and the byte-wide CRC-16/XMODEM update.
// No dependencies.
`default_nettype none

package frx_pkg;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN1 = 3'd1,
    PH_LEN2 = 3'd2,
    PH_BODY = 3'd3,
    PH_CRC  = 3'd4,
    PH_END  = 3'd5
  } phase_t;

  localparam int unsigned ADDR_W = 3;

  typedef enum logic {
    REG_START = 1'b0,
    REG_END   = 1'b1
  } reg_idx_t;

  localparam logic [7:0]  START_BYTE_RST = 8'h02;
  localparam logic [7:0]  END_BYTE_RST   = 8'h03;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] MAX_PAYLOAD    = 16'd256;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/framed_packet_receiver_crc16.sv
// Framed packet receiver: start byte, doubled length, payload, CRC-16/XMODEM,
// end byte. Depends on frx_pkg.
//
// Throughput: one byte per cycle, back to back, while the input is not stalled.
// A result is registered when its end byte is accepted.
// A second result register (skid) lets the input keep running while a result
// waits; the input stalls only while that skid register is full.
// Reset is synchronous, active low: hunting, all deframer state zero, registers at
// start 0x02 and end 0x03.
`default_nettype none

module framed_packet_receiver_crc16 (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Byte input channel.
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_rx_byte,
  // Result channel.
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_status,
  output logic [7:0]                      out_command,
  output logic [31:0]                     out_data_word,
  output logic [8:0]                      out_payload_length,
  // Configuration port.
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [frx_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // ---------------------------------------------------------------------
  // Configuration registers. Register index is address bit 2, the low bit of the word address.
  // ---------------------------------------------------------------------
  logic [7:0] start_byte_r;
  logic [7:0] end_byte_r;
  logic       cfg_we;
  frx_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = frx_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= frx_pkg::START_BYTE_RST;
      end_byte_r   <= frx_pkg::END_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        frx_pkg::REG_START: start_byte_r <= pwdata[7:0];
        frx_pkg::REG_END:   end_byte_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      frx_pkg::REG_START: prdata = {24'd0, start_byte_r};
      frx_pkg::REG_END:   prdata = {24'd0, end_byte_r};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Deframer state.
  // ---------------------------------------------------------------------
  frx_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [7:0]  len2_lo_r, len2_lo_nxt;
  logic        half_r, half_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [31:0] staged_r, staged_nxt;
  logic [31:0] held_r, held_nxt;

  logic        in_acc;
  logic        res_valid;
  logic        res_status;
  logic [15:0] crc_step;
  logic [15:0] pos;
  logic [15:0] len2;
  logic [15:0] ndata;
  logic [16:0] crc_cnt;
  logic [31:0] upd_mask;

  assign in_acc   = in_valid && !in_stall;
  assign crc_step = frx_pkg::crc16_byte(crc_r, in_rx_byte);
  // Position of this byte inside the payload; zero is the command byte.
  assign pos      = frame_len_r - left_r;
  assign len2     = {in_rx_byte, len2_lo_r};
  assign ndata    = frame_len_r - 16'd1;
  assign crc_cnt  = {1'b0, left_r} + 17'd1;

  // Bytes of the held word that a good frame overwrites.
  always_comb begin
    case (ndata)
      16'd0:   upd_mask = 32'h0000_0000;
      16'd1:   upd_mask = 32'h0000_00FF;
      16'd2:   upd_mask = 32'h0000_FFFF;
      16'd3:   upd_mask = 32'h00FF_FFFF;
      default: upd_mask = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    len2_lo_nxt   = len2_lo_r;
    half_nxt      = half_r;
    left_nxt      = left_r;
    crc_nxt       = crc_r;
    cmd_nxt       = cmd_r;
    staged_nxt    = staged_r;
    held_nxt      = held_r;
    res_valid     = 1'b0;
    res_status    = 1'b0;

    if (in_acc) begin
      unique case (phase_r)
        frx_pkg::PH_LEN1: begin
          if (!half_r) begin
            frame_len_nxt = {8'd0, in_rx_byte};
            half_nxt      = 1'b1;
          end else begin
            frame_len_nxt = {in_rx_byte, frame_len_r[7:0]};
            left_nxt      = {in_rx_byte, frame_len_r[7:0]};
            staged_nxt    = 32'd0;
            cmd_nxt       = 8'd0;
            crc_nxt       = 16'd0;
            half_nxt      = 1'b0;
            phase_nxt     = frx_pkg::PH_LEN2;
          end
        end
        frx_pkg::PH_LEN2: begin
          if (!half_r) begin
            len2_lo_nxt = in_rx_byte;
            half_nxt    = 1'b1;
          end else begin
            half_nxt = 1'b0;
            // Mismatched copies or an out-of-range length drop the frame.
            if (len2 != frame_len_r || frame_len_r == 16'd0 ||
                frame_len_r > frx_pkg::MAX_PAYLOAD) begin
              phase_nxt     = frx_pkg::PH_HUNT;
              frame_len_nxt = 16'd0;
              len2_lo_nxt   = 8'd0;
              left_nxt      = 16'd0;
            end else begin
              phase_nxt = frx_pkg::PH_BODY;
            end
          end
        end
        frx_pkg::PH_BODY: begin
          case (pos)
            16'd0:   cmd_nxt = in_rx_byte;
            16'd1:   staged_nxt = staged_r | {24'd0, in_rx_byte};
            16'd2:   staged_nxt = staged_r | {16'd0, in_rx_byte, 8'd0};
            16'd3:   staged_nxt = staged_r | {8'd0, in_rx_byte, 16'd0};
            16'd4:   staged_nxt = staged_r | {in_rx_byte, 24'd0};
            default: ;
          endcase
          crc_nxt  = crc_step;
          left_nxt = left_r - 16'd1;
          if (left_r == 16'd1) begin
            phase_nxt = frx_pkg::PH_CRC;
          end
        end
        frx_pkg::PH_CRC: begin
          crc_nxt  = crc_step;
          left_nxt = crc_cnt[15:0];
          if (crc_cnt >= 17'd2) begin
            left_nxt  = 16'd0;
            phase_nxt = frx_pkg::PH_END;
          end
        end
        frx_pkg::PH_END: begin
          phase_nxt     = frx_pkg::PH_HUNT;
          frame_len_nxt = 16'd0;
          if (in_rx_byte != end_byte_r) begin
            left_nxt = 16'd0;
          end else begin
            res_valid  = 1'b1;
            res_status = (crc_r != 16'd0);
            if (crc_r == 16'd0) begin
              held_nxt = (held_r & ~upd_mask) | (staged_r & upd_mask);
            end
          end
        end
        default: begin
          // Hunting; unused codes behave the same way.
          phase_nxt = frx_pkg::PH_HUNT;
          if (in_rx_byte == start_byte_r) begin
            phase_nxt     = frx_pkg::PH_LEN1;
            frame_len_nxt = 16'd0;
            half_nxt      = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= frx_pkg::PH_HUNT;
      frame_len_r <= 16'd0;
      len2_lo_r   <= 8'd0;
      half_r      <= 1'b0;
      left_r      <= 16'd0;
      crc_r       <= 16'd0;
      cmd_r       <= 8'd0;
      staged_r    <= 32'd0;
      held_r      <= 32'd0;
    end else begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      len2_lo_r   <= len2_lo_nxt;
      half_r      <= half_nxt;
      left_r      <= left_nxt;
      crc_r       <= crc_nxt;
      cmd_r       <= cmd_nxt;
      staged_r    <= staged_nxt;
      held_r      <= held_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result path: output register plus one skid register. The skid only
  // fills when a new result arrives while the output is stalled, and the
  // input is stalled while it is full, so no result is ever dropped.
  // ---------------------------------------------------------------------
  logic        out_valid_r;
  logic        out_status_r;
  logic [7:0]  out_cmd_r;
  logic [31:0] out_word_r;
  logic [8:0]  out_len_r;
  logic        skid_valid_r;
  logic        skid_status_r;
  logic [7:0]  skid_cmd_r;
  logic [31:0] skid_word_r;
  logic [8:0]  skid_len_r;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || res_valid;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_status_r <= skid_status_r;
        out_cmd_r    <= skid_cmd_r;
        out_word_r   <= skid_word_r;
        out_len_r    <= skid_len_r;
      end else if (res_valid) begin
        out_status_r <= res_status;
        out_cmd_r    <= cmd_r;
        out_word_r   <= held_nxt;
        out_len_r    <= frame_len_r[8:0];
      end
    end else if (res_valid) begin
      skid_status_r <= res_status;
      skid_cmd_r    <= cmd_r;
      skid_word_r   <= held_nxt;
      skid_len_r    <= frame_len_r[8:0];
    end
  end

  assign in_stall           = skid_valid_r;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_command        = out_cmd_r;
  assign out_data_word      = out_word_r;
  assign out_payload_length = out_len_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // The skid register only holds a result behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // A new result only follows an accepted end byte.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && phase_r == frx_pkg::PH_END))
    else $error("result appeared without an accepted end byte");

  // While the payload is read there is always at least one byte left.
  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == frx_pkg::PH_BODY) |-> (left_r != 16'd0))
    else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

// File: test/framed_packet_receiver_crc16_tb.sv
// Self-checking testbench for framed_packet_receiver_crc16: byte stream in, one
// result per closed frame out. It carries its own deframer and CRC-16/XMODEM model.
// Depends on frx_pkg and the receiver RTL only.

module framed_packet_receiver_crc16_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD    = 10;
  localparam int          RESET_CYCLES  = 12;
  // Room for a result in the output register plus one in the skid slot.
  localparam int          SETTLE_CYCLES = 4;
  localparam int          QUIET_LIMIT   = 4000;
  localparam int          BYTES_PER_SET = 350;
  localparam logic [15:0] XMODEM_POLY   = 16'h1021;

  // One result as the block reports it.
  typedef struct packed {
    logic        status;
    logic [7:0]  command;
    logic [31:0] data_word;
    logic [8:0]  payload_length;
  } frame_result_t;

  // Shapes of frame the stimulus can build.
  typedef enum logic [2:0] {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_END,
    FR_LEN_MISMATCH,
    FR_LEN_ZERO,
    FR_LEN_OVER,
    FR_NOISE
  } frame_kind_t;

  // A directed row: one frame, with its result typed in where it is obvious.
  typedef struct packed {
    frame_kind_t   kind;
    logic [15:0]   len;
    logic [7:0]    cmd;
    logic [7:0]    fill;
    logic          typed;
    frame_result_t res;
  } frame_row_t;

  // Directed frames. The registers are at their reset values (start 0x02,
  // end 0x03) and the held word starts at zero.
  localparam int DIRECTED_ROWS = 13;
  frame_row_t directed_rows [DIRECTED_ROWS] = '{
    // Both byte extremes while hunting; the block must ignore them.
    '{FR_NOISE,        16'd1,   8'h00, 8'hFF, 1'b0, '0},
    '{FR_NOISE,        16'd1,   8'h00, 8'h00, 1'b0, '0},
    // CRC error straight after reset: NACK with the untouched zero word.
    '{FR_BAD_CRC,      16'd1,   8'hA5, 8'h00, 1'b1, '{1'b1, 8'hA5, 32'h0, 9'd1}},
    // Short payloads: only one, then two low bytes of the word change.
    '{FR_GOOD,         16'd2,   8'h00, 8'hFF, 1'b0, '0},
    '{FR_GOOD,         16'd3,   8'hFF, 8'h11, 1'b0, '0},
    // Broken length headers drop back to hunting without a result.
    '{FR_LEN_MISMATCH, 16'd4,   8'h00, 8'h00, 1'b0, '0},
    '{FR_LEN_ZERO,     16'd0,   8'h00, 8'h00, 1'b0, '0},
    '{FR_LEN_OVER,     16'd257, 8'h00, 8'h00, 1'b0, '0},
    // Wrong closing byte: the frame vanishes silently.
    '{FR_BAD_END,      16'd2,   8'h33, 8'h44, 1'b0, '0},
    // The start byte inside a frame is plain data, here as the command.
    '{FR_GOOD,         16'd1,   8'h02, 8'h00, 1'b0, '0},
    // Long payload: bytes past the fourth data byte only feed the CRC.
    '{FR_GOOD,         16'd7,   8'h5C, 8'h02, 1'b0, '0},
    '{FR_BAD_CRC,      16'd5,   8'hC3, 8'hEE, 1'b0, '0},
    '{FR_GOOD,         16'd5,   8'h00, 8'hFF, 1'b0, '0}
  };

  // Traffic settings. The sender idles and the receiver stalls with these
  // percentages; each set after the first also rewrites both registers.
  localparam int TRAFFIC_SETS = 5;
  int unsigned set_idle_pct  [TRAFFIC_SETS] = '{0, 86, 0, 9, 0};
  int unsigned set_stall_pct [TRAFFIC_SETS] = '{0, 0, 86, 9, 0};
  logic [7:0]  set_open      [TRAFFIC_SETS] = '{8'h02, 8'h00, 8'hFF, 8'h7E, 8'h00};
  logic [7:0]  set_close     [TRAFFIC_SETS] = '{8'h03, 8'hFF, 8'h00, 8'h7E, 8'h00};

  // Clock, reset and every block input start at known values.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_stall  = 1'b0;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [frx_pkg::ADDR_W-1:0] paddr  = '0;
  logic [31:0]                pwdata = '0;

  logic        in_stall;
  logic        out_valid;
  logic        out_status;
  logic [7:0]  out_command;
  logic [31:0] out_data_word;
  logic [8:0]  out_payload_length;
  logic [31:0] prdata;
  logic        pready;

  framed_packet_receiver_crc16 uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_command       (out_command),
    .out_data_word     (out_data_word),
    .out_payload_length(out_payload_length),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Deframer state mirrored from the block, with its own copy of the
  // registers. Everything starts as the block leaves reset.
  frx_pkg::phase_t rx_phase = frx_pkg::PH_HUNT;
  logic [15:0] rx_len     = '0;
  logic [7:0]  rx_len2_lo = '0;
  logic        rx_half    = 1'b0;
  logic [15:0] rx_left    = '0;
  logic [15:0] rx_crc     = '0;
  logic [7:0]  rx_cmd     = '0;
  logic [31:0] rx_staged  = '0;
  logic [31:0] rx_held    = '0;
  logic [7:0]  cfg_start  = frx_pkg::START_BYTE_RST;
  logic [7:0]  cfg_end    = frx_pkg::END_BYTE_RST;

  frame_result_t frame_results_due [$];
  logic [7:0]    frame_bytes [$];
  int unsigned   fail_count  = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   in_idle_pct   = 0;
  int unsigned   out_stall_pct = 0;

  // What the sender currently offers beside the byte: whether this request
  // closes a directed frame whose result is typed in.
  logic          cur_typed = 1'b0;
  frame_result_t cur_typed_res = '0;

  bit            step_emit;
  frame_result_t step_res;

  // CRC-16/XMODEM, one message bit at a time, MSB first.
  function automatic logic [15:0] xmodem_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? XMODEM_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Advance the deframer by one received byte. A result comes out only at a
  // matching end byte, good CRC or not.
  task automatic deframe_byte(input logic [7:0] b, output bit emit,
                              output frame_result_t r);
    logic [15:0] pos;
    logic [15:0] second;
    logic [15:0] ndata;
    logic [31:0] mask;
    emit = 1'b0;
    r    = '0;
    case (rx_phase)
      frx_pkg::PH_LEN1: begin
        if (!rx_half) begin
          rx_len  = {8'h00, b};
          rx_half = 1'b1;
        end else begin
          rx_len    = {b, rx_len[7:0]};
          rx_left   = rx_len;
          rx_staged = '0;
          rx_cmd    = '0;
          rx_crc    = '0;
          rx_half   = 1'b0;
          rx_phase  = frx_pkg::PH_LEN2;
        end
      end
      frx_pkg::PH_LEN2: begin
        if (!rx_half) begin
          rx_len2_lo = b;
          rx_half    = 1'b1;
        end else begin
          second  = {b, rx_len2_lo};
          rx_half = 1'b0;
          if (second != rx_len || rx_len == 16'd0 ||
              rx_len > frx_pkg::MAX_PAYLOAD) begin
            rx_phase   = frx_pkg::PH_HUNT;
            rx_len     = '0;
            rx_len2_lo = '0;
            rx_left    = '0;
          end else begin
            rx_phase = frx_pkg::PH_BODY;
          end
        end
      end
      frx_pkg::PH_BODY: begin
        pos = rx_len - rx_left;
        if (pos == 16'd0) begin
          rx_cmd = b;
        end else if (pos <= 16'd4) begin
          rx_staged = rx_staged | ({24'h0, b} << (8 * (pos - 16'd1)));
        end
        rx_crc  = xmodem_next(rx_crc, b);
        rx_left = rx_left - 16'd1;
        if (rx_left == 16'd0) begin
          rx_phase = frx_pkg::PH_CRC;
        end
      end
      frx_pkg::PH_CRC: begin
        rx_crc  = xmodem_next(rx_crc, b);
        rx_left = rx_left + 16'd1;
        if (rx_left >= 16'd2) begin
          rx_left  = '0;
          rx_phase = frx_pkg::PH_END;
        end
      end
      frx_pkg::PH_END: begin
        rx_phase = frx_pkg::PH_HUNT;
        if (b != cfg_end) begin
          rx_len  = '0;
          rx_left = '0;
        end else begin
          if (rx_crc == 16'd0) begin
            ndata = rx_len - 16'd1;
            if (ndata >= 16'd4) begin
              mask = '1;
            end else begin
              mask = (32'd1 << (8 * ndata)) - 32'd1;
            end
            rx_held = (rx_held & ~mask) | (rx_staged & mask);
          end
          emit             = 1'b1;
          r.status         = (rx_crc != 16'd0);
          r.command        = rx_cmd;
          r.data_word      = rx_held;
          r.payload_length = rx_len[8:0];
          rx_len           = '0;
        end
      end
      default: begin
        rx_phase = frx_pkg::PH_HUNT;
        if (b == cfg_start) begin
          rx_phase = frx_pkg::PH_LEN1;
          rx_len   = '0;
          rx_half  = 1'b0;
        end
      end
    endcase
  endtask

  function automatic bit roll_pct(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Mostly short payloads, some medium, and now and then one within three bytes of the maximum.
  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      return 16'($urandom_range(1, 6));
    end else if (r < 97) begin
      return 16'($urandom_range(7, 40));
    end else begin
      return 16'($urandom_range(frx_pkg::MAX_PAYLOAD - 3, frx_pkg::MAX_PAYLOAD));
    end
  endfunction

  // Lay one frame out in frame_bytes. The CRC is appended high byte first,
  // which is what leaves a zero residue over payload plus CRC.
  task automatic build_frame(input frame_kind_t kind, input logic [15:0] len,
                             input logic [7:0] cmd, input logic [7:0] fill,
                             input bit rand_data);
    logic [15:0] crc;
    logic [15:0] len2;
    logic [7:0]  b;
    frame_bytes.delete();
    if (kind == FR_NOISE) begin
      // Line noise between frames never holds the start byte, so that the
      // next frame is still taken from its own start.
      for (int i = 0; i < len; i++) begin
        b = rand_data ? 8'($urandom_range(255)) : fill;
        if (b == cfg_start) begin
          b = ~b;
        end
        frame_bytes.push_back(b);
      end
    end else begin
      len2 = len;
      if (kind == FR_LEN_MISMATCH) begin
        len2 = len ^ 16'($urandom_range(1, 65535));
      end
      frame_bytes.push_back(cfg_start);
      frame_bytes.push_back(len[7:0]);
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len2[7:0]);
      frame_bytes.push_back(len2[15:8]);
      // A broken header ends the frame here: the block is hunting again.
      if (kind != FR_LEN_MISMATCH && kind != FR_LEN_ZERO && kind != FR_LEN_OVER) begin
        crc = '0;
        for (int i = 0; i < len; i++) begin
          if (i == 0) begin
            b = cmd;
          end else begin
            b = rand_data ? 8'($urandom_range(255)) : fill;
          end
          frame_bytes.push_back(b);
          crc = xmodem_next(crc, b);
        end
        // A single corrupted CRC byte always leaves a nonzero residue.
        if (kind == FR_BAD_CRC) begin
          if ($urandom_range(1)) begin
            crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
          end else begin
            crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
          end
        end
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
        b = cfg_end;
        if (kind == FR_BAD_END) begin
          b = 8'($urandom_range(255));
          if (b == cfg_end) begin
            b = ~b;
          end
        end
        frame_bytes.push_back(b);
      end
    end
  endtask

  // Offer one byte after a random idle gap and hold it until accepted.
  // Everything changes on the falling edge; acceptance is seen on the rising.
  task automatic push_byte(input logic [7:0] b, input logic typed,
                           input frame_result_t tr);
    @(negedge clk);
    while (roll_pct(in_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_rx_byte    <= b;
    cur_typed     <= typed;
    cur_typed_res <= tr;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Send the frame in frame_bytes. A typed result rides on its end byte.
  task automatic send_frame(input logic typed, input frame_result_t tr);
    foreach (frame_bytes[i]) begin
      push_byte(frame_bytes[i], typed && (i == frame_bytes.size() - 1), tr);
    end
  endtask

  // Stop sending and let every outstanding result come out; the extra
  // cycles cover a result still on its way through the skid register.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready. Only called while the
  // block has nothing pending, so the model register changes at once.
  task automatic reg_write(input frx_pkg::reg_idx_t idx, input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    if (idx == frx_pkg::REG_START) begin
      cfg_start = value;
    end else begin
      cfg_end = value;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random frames: mostly well formed with random content, the rest broken
  // headers, bad CRCs, wrong end bytes and line noise.
  task automatic random_frame(output int unsigned counted);
    int unsigned r;
    frame_kind_t kind;
    logic [15:0] len;
    r   = $urandom_range(99);
    len = pick_length();
    if (r < 55) begin
      kind = FR_GOOD;
    end else if (r < 70) begin
      kind = FR_BAD_CRC;
    end else if (r < 78) begin
      kind = FR_BAD_END;
    end else if (r < 84) begin
      kind = FR_LEN_MISMATCH;
    end else if (r < 87) begin
      kind = FR_LEN_ZERO;
      len  = '0;
    end else if (r < 92) begin
      kind = FR_LEN_OVER;
      len  = 16'($urandom_range(frx_pkg::MAX_PAYLOAD + 1, 65535));
    end else begin
      kind = FR_NOISE;
      len  = 16'($urandom_range(1, 6));
    end
    build_frame(kind, len, 8'($urandom_range(255)), 8'h00, 1'b1);
    send_frame(1'b0, '0);
    // Noise is ignored by the block and does not count toward the volume.
    counted = (kind == FR_NOISE) ? 0 : frame_bytes.size();
  endtask

  // Receiver side: stall at random on the falling edge.
  always @(negedge clk) begin
    out_stall <= roll_pct(out_stall_pct);
  end

  // Every accepted byte steps the model; a closed frame queues its result.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      deframe_byte(in_rx_byte, step_emit, step_res);
      if (step_emit) begin
        frame_results_due.push_back(cur_typed ? cur_typed_res : step_res);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Every accepted result is matched against the oldest one due.
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results_due.size() == 0) begin
        $error("unexpected result: status %0b command 0x%0h data 0x%0h length %0d",
               out_status, out_command, out_data_word, out_payload_length);
        fail_count++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("command", 32'(want.command), 32'(out_command));
        check_field("data_word", want.data_word, out_data_word);
        check_field("payload_length", 32'(want.payload_length),
                    32'(out_payload_length));
      end
    end
  end

  // Watchdog: too long without any request moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned counted;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames at reset register values, no idling.
    foreach (directed_rows[i]) begin
      build_frame(directed_rows[i].kind, directed_rows[i].len, directed_rows[i].cmd,
                  directed_rows[i].fill, 1'b0);
      send_frame(directed_rows[i].typed, directed_rows[i].res);
    end

    // Random traffic in several settings; registers change only once the
    // block has delivered everything and gone quiet.
    for (int s = 0; s < TRAFFIC_SETS; s++) begin
      if (s != 0) begin
        drain_results();
        if (s == TRAFFIC_SETS - 1) begin
          set_open[s]  = 8'($urandom_range(255));
          set_close[s] = 8'($urandom_range(255));
        end
        reg_write(frx_pkg::REG_START, set_open[s]);
        reg_write(frx_pkg::REG_END, set_close[s]);
      end
      in_idle_pct   = set_idle_pct[s];
      out_stall_pct = set_stall_pct[s];
      sent = 0;
      while (sent < BYTES_PER_SET) begin
        random_frame(counted);
        sent += counted;
      end
    end

    drain_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
